>>> sv/mgmhd_pkg.sv
// ----------------------------------------------------------------------------
// mgmhd_pkg
// Shared constants, types and helpers of the median-gated mean hotspot block.
// ----------------------------------------------------------------------------
package mgmhd_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int MEAN_W       = 24;
    localparam int PIX_W        = 10;
    localparam int COUNT_W      = 11;
    localparam int MAX_SENSORS  = 8;
    localparam int CNT_W        = 4;   // holds 0..8 accepted readings
    localparam int CFG_IDX_W    = 1;

    localparam int DEF_SENSORS       = 8;
    localparam int DEF_PIXELS        = 1024;
    localparam int DEF_FRACTION_BITS = 8;

    // widest sum shifted by the fraction: 19 bits of sum plus up to 16
    localparam int NUM_W = 35;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRANTED_ERROR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HOT_THRESHOLD = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [MEAN_W-1:0]  MEAN_MAX  = '1;

    typedef logic [SAMPLE_W-1:0] sample_t;

    // controller -> datapath
    typedef struct packed {
        logic clear;     // zero one reference entry
        logic load;      // capture input word
        logic sort_step; // one odd/even transposition pass
        logic gate;      // median and window sum
        logic div_init;  // start the divider
        logic div_step;  // one restoring step
        logic ref_read;  // read reference store
        logic finish;    // compute result, update store and count
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic div_last;
    } dp_status_t;

endpackage

>>> sv/mgmhd_datapath.sv
// ----------------------------------------------------------------------------
// mgmhd_datapath
// Sorter, window gate, iterative divider, reference memory and hotspot count.
// ----------------------------------------------------------------------------
module mgmhd_datapath #(
    parameter int SENSORS       = mgmhd_pkg::DEF_SENSORS,
    parameter int PIXELS        = mgmhd_pkg::DEF_PIXELS,
    parameter int FRACTION_BITS = mgmhd_pkg::DEF_FRACTION_BITS
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  mgmhd_pkg::dp_cmd_t                         cmd,
    output mgmhd_pkg::dp_status_t                      status,
    input  mgmhd_pkg::sample_t [mgmhd_pkg::MAX_SENSORS-1:0] in_samples,
    input  logic [mgmhd_pkg::PIX_W-1:0]                in_pixel,
    input  logic                                       in_ref_frame,
    input  logic                                       in_frame_start,
    input  logic [15:0]                                granted_error,
    input  logic [15:0]                                hotspot_threshold,
    output logic [mgmhd_pkg::MEAN_W-1:0]               mean_value,
    output logic [mgmhd_pkg::MEAN_W-1:0]               excess,
    output logic                                       is_hotspot,
    output logic [mgmhd_pkg::COUNT_W-1:0]              hotspot_count,
    output logic                                       window_empty
);
    import mgmhd_pkg::*;

    localparam int N     = SENSORS;
    localparam int ADR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int STEP_W = $clog2(NUM_W + 1);

    sample_t                v_reg [N];
    logic [PIX_W-1:0]       pix_reg;
    logic                   ref_frame_reg, frame_start_reg;

    logic [NUM_W-1:0]       num_reg;    // dividend, shifts into quotient
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W:0]         rem_reg;
    logic [STEP_W-1:0]      step_reg;
    logic                   empty_reg;

    logic [MEAN_W-1:0]      mem [PIXELS];
    logic [MEAN_W-1:0]      rd_reg;
    logic                   rd_ok_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic [ADR_W-1:0]       clr_adr_reg;

    logic [MEAN_W-1:0]      mean_reg, excess_reg;
    logic                   hot_reg;

    // odd/even transposition pass, phase from step counter
    sample_t                v_sorted [N];
    always_comb begin
        for (int i = 0; i < N; i++) v_sorted[i] = v_reg[i];
        for (int i = 0; i + 1 < N; i++) begin
            if ((i % 2) == int'(step_reg[0]) && v_reg[i] > v_reg[i+1]) begin
                v_sorted[i]   = v_reg[i+1];
                v_sorted[i+1] = v_reg[i];
            end
        end
    end

    // median and gated sum over sorted readings
    logic [SAMPLE_W:0]      med_sum;
    logic signed [18:0]     median, lo, hi;
    logic [18:0]            gsum;
    logic [CNT_W-1:0]       gcnt;
    always_comb begin
        if ((N % 2) == 0)
            med_sum = ({1'b0, v_reg[N/2]} + {1'b0, v_reg[(N/2 == 0) ? 0 : N/2-1]}) >> 1;
        else
            med_sum = {1'b0, v_reg[N/2]};
        median = signed'({2'b00, med_sum});
        lo = median - signed'({3'b000, granted_error});
        hi = median + signed'({3'b000, granted_error});
        gsum = '0;
        gcnt = '0;
        for (int i = 0; i < N; i++) begin
            if (signed'({3'b000, v_reg[i]}) > lo && signed'({3'b000, v_reg[i]}) < hi) begin
                gsum = gsum + 19'(v_reg[i]);
                gcnt = gcnt + 1'b1;
            end
        end
    end

    // restoring divider step
    logic [CNT_W:0]         rem_sh;
    logic                   q_bit;
    always_comb begin
        rem_sh = {rem_reg[CNT_W-1:0], num_reg[NUM_W-1]};
        q_bit  = rem_sh >= {1'b0, cnt_reg};
    end
    assign status.div_last   = (step_reg == STEP_W'(NUM_W - 1));
    assign status.clear_last = (clr_adr_reg == ADR_W'(PIXELS - 1));

    // result arithmetic
    logic [MEAN_W-1:0]      mean_c, refv, exc_c;
    logic                   hot_c;
    always_comb begin
        if (empty_reg) mean_c = '0;
        else if (num_reg > NUM_W'(MEAN_MAX)) mean_c = MEAN_MAX;
        else mean_c = num_reg[MEAN_W-1:0];
        refv  = rd_ok_reg ? rd_reg : '0;
        exc_c = (!ref_frame_reg && mean_c > refv) ? mean_c - refv : '0;
        hot_c = !ref_frame_reg &&
                ({8'd0, exc_c} > (32'(hotspot_threshold) << FRACTION_BITS));
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (cmd.clear)
            mem[clr_adr_reg] <= '0;
        if (cmd.load) begin
            for (int i = 0; i < N; i++) v_reg[i] <= in_samples[i];
            pix_reg         <= in_pixel;
            ref_frame_reg   <= in_ref_frame;
            frame_start_reg <= in_frame_start;
            step_reg        <= '0;
        end
        if (cmd.sort_step) begin
            for (int i = 0; i < N; i++) v_reg[i] <= v_sorted[i];
            step_reg <= step_reg + 1'b1;
        end
        if (cmd.gate) begin
            num_reg   <= NUM_W'(gsum) << FRACTION_BITS;
            cnt_reg   <= gcnt;
            empty_reg <= (gcnt == '0);
        end
        if (cmd.div_init) begin
            rem_reg  <= '0;
            step_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg  <= q_bit ? rem_sh - {1'b0, cnt_reg} : rem_sh;
            num_reg  <= {num_reg[NUM_W-2:0], q_bit};
            step_reg <= step_reg + 1'b1;
        end
        if (cmd.ref_read) begin
            rd_reg    <= mem[ADR_W'(pix_reg)];
            rd_ok_reg <= (32'(pix_reg) < PIXELS);
        end
        if (cmd.finish) begin
            mean_reg   <= mean_c;
            excess_reg <= exc_c;
            hot_reg    <= hot_c;
            if (ref_frame_reg && 32'(pix_reg) < PIXELS)
                mem[ADR_W'(pix_reg)] <= mean_c;
        end
    end

    // clearing pass address after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_adr_reg <= '0;
        end else if (cmd.clear) begin
            clr_adr_reg <= clr_adr_reg + 1'b1;
        end
    end

    // hotspot count per frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.finish) begin
            if (frame_start_reg)
                count_reg <= hot_c ? COUNT_W'(1) : '0;
            else if (hot_c && count_reg != COUNT_MAX)
                count_reg <= count_reg + 1'b1;
        end
    end

    assign mean_value    = mean_reg;
    assign excess        = excess_reg;
    assign is_hotspot    = hot_reg;
    assign hotspot_count = count_reg;
    assign window_empty  = empty_reg;

    // a reported hotspot always has nonzero excess
    a_hot_excess: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd.finish) && hot_reg |-> excess_reg != '0) else $error("hot w/o excess");
    // excess never above mean
    a_exc_le_mean: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd.finish) |-> excess_reg <= mean_reg) else $error("excess > mean");
    // count only moves on finish
    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(cmd.finish) && $past(aresetn) |-> $stable(count_reg)) else $error("count moved");

endmodule

>>> sv/mgmhd_ctrl.sv
// ----------------------------------------------------------------------------
// mgmhd_ctrl
// Sequencer: clearing pass, load, sort passes, gate, divide, reference read, result hand-off.
// ----------------------------------------------------------------------------
module mgmhd_ctrl #(
    parameter int SENSORS = mgmhd_pkg::DEF_SENSORS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output mgmhd_pkg::dp_cmd_t    cmd,
    input  mgmhd_pkg::dp_status_t status
);
    import mgmhd_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SORT = 3'd1;
    localparam logic [2:0] ST_GATE = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_REF  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;
    localparam logic [2:0] ST_CLR  = 3'd7;

    localparam int PASS_W = 4;

    logic [2:0]        state_reg, state_next;
    logic [PASS_W-1:0] pass_reg, pass_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        pass_next  = pass_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLR: begin
                cmd.clear = 1'b1;
                if (status.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    pass_next  = '0;
                    state_next = ST_SORT;
                end
            end
            ST_SORT: begin
                cmd.sort_step = 1'b1;
                pass_next     = pass_reg + 1'b1;
                if (pass_reg == PASS_W'(SENSORS - 1) || SENSORS == 1)
                    state_next = ST_GATE;
            end
            ST_GATE: begin
                cmd.gate     = 1'b1;
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) state_next = ST_REF;
            end
            ST_REF: begin
                cmd.ref_read = 1'b1;
                state_next   = ST_FIN;
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
            pass_reg  <= '0;
        end else begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    // result is held until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    // never accept while a result is pending
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready with result");
    // finish comes right after reference read
    a_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ref_read |=> cmd.finish) else $error("sequence slip");

endmodule

>>> sv/median_gated_mean_hotspot_detector_top.sv
// ----------------------------------------------------------------------------
// median_gated_mean_hotspot_detector_top
// Sorts up to eight readings per pixel, averages those near the median and
// flags pixels whose mean exceeds a stored reference by a threshold.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per pixel (samples, pixel index, frame flags).
//   m_ channel: one result word per input word, in order.
//   cfg channel: index 0 granted_error, 1 hotspot_threshold; write when idle.
//   Sequence: SENSORS sort passes, gate, 35 divider steps, reference read
//   and finish, then m_valid; the restoring divider is one-bit-per-cycle.
//   Throughput: one pixel at a time, a new word is taken only after the
//   result of the last is taken; s_ready returns the cycle after the
//   result word is taken.
//   Reset: registers return to 64 / 32, hotspot count to zero. A clearing
//   pass then zeroes all PIXELS entries (1024 by default) of the reference
//   store; s_ready stays low until it ends.
//   Stall: the result is held on m_ until m_ready, the input stays blocked.
// ----------------------------------------------------------------------------
module median_gated_mean_hotspot_detector_top #(
    parameter int SENSORS       = mgmhd_pkg::DEF_SENSORS,
    parameter int PIXELS        = mgmhd_pkg::DEF_PIXELS,
    parameter int FRACTION_BITS = mgmhd_pkg::DEF_FRACTION_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_sample_0,
    input  logic [15:0] s_sample_1,
    input  logic [15:0] s_sample_2,
    input  logic [15:0] s_sample_3,
    input  logic [15:0] s_sample_4,
    input  logic [15:0] s_sample_5,
    input  logic [15:0] s_sample_6,
    input  logic [15:0] s_sample_7,
    input  logic [9:0]  s_pixel_index,
    input  logic        s_reference_frame,
    input  logic        s_frame_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [23:0] m_mean_value,
    output logic [23:0] m_excess,
    output logic        m_is_hotspot,
    output logic [10:0] m_hotspot_count,
    output logic        m_window_empty,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [mgmhd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0] cfg_data
);
    import mgmhd_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [15:0] granted_error_reg, threshold_reg;
    sample_t [MAX_SENSORS-1:0] samples;

    assign samples = {s_sample_7, s_sample_6, s_sample_5, s_sample_4,
                      s_sample_3, s_sample_2, s_sample_1, s_sample_0};

    // configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            granted_error_reg <= 16'd64;
            threshold_reg     <= 16'd32;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_GRANTED_ERROR: granted_error_reg <= cfg_data;
                REG_HOT_THRESHOLD: threshold_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    mgmhd_ctrl #(.SENSORS(SENSORS)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
        .cmd, .status
    );

    mgmhd_datapath #(
        .SENSORS(SENSORS), .PIXELS(PIXELS), .FRACTION_BITS(FRACTION_BITS)
    ) u_dp (
        .aclk, .aresetn, .cmd, .status,
        .in_samples(samples), .in_pixel(s_pixel_index),
        .in_ref_frame(s_reference_frame), .in_frame_start(s_frame_start),
        .granted_error(granted_error_reg), .hotspot_threshold(threshold_reg),
        .mean_value(m_mean_value), .excess(m_excess), .is_hotspot(m_is_hotspot),
        .hotspot_count(m_hotspot_count), .window_empty(m_window_empty)
    );

endmodule
